// ===== design/swhc_pkg.sv =====
package swhc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned WIN_W   = 9;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 9'd300;
  localparam logic [DATA_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

  // tuser command codes
  localparam logic CMD_HIT   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EVICT,
    ST_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic load;      // latch the accepted item
    logic exec;      // hit: push or bump; query: nothing
    logic pop;       // drop the head record
    logic out_load;  // move the total into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic hit_simple;  // empty ring or same time as newest record
    logic old_head;    // ring not empty and head record out of window
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/sliding_window_hit_counter_core.sv =====
// Sliding-window hit counter.
// Input stream: s_axis_tuser is the command (0 = hit, 1 = query) and
// s_axis_tdata the timestamp in ticks, non-decreasing. A hit yields no
// output; a query yields one m_axis transaction carrying the number of hits
// whose age (query time minus hit time) is below window_length.
// window_length sits at APB byte address 0, reset 300; write it only while
// the block is idle.
// Timing: an item is taken in ST_IDLE and executed in the next state, ST_EXEC, so a hit
// that bumps the newest record or lands on an empty ring then returns to idle.
// A push at a new time and a query then check the head record and evict each
// aged record in turn; the head record read from the ring memory is ready
// every cycle, so eviction runs at one record a cycle.
// A query result then goes into the registered m_axis output once that is free.
// Reset empties the ring and clears the total; no clearing pass is needed.
// When the receiver stalls, a result waits in the output register; the next
// item is still accepted and runs until its own result needs that register.
module sliding_window_hit_counter_core #(
  parameter int unsigned RING_DEPTH = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] timestamp
  input  logic [0:0]  s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] hit_count
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swhc_pkg::*;

  logic [WIN_W-1:0] window_length;
  logic             reg_sel;
  ctrl_cmd_t        cmd;
  dp_status_t       status;

  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(32 - WIN_W){1'b0}}, window_length} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      window_length <= pwdata[WIN_W-1:0];
    end
  end

  swhc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swhc_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_command    (s_axis_tuser[0]),
    .in_time       (s_axis_tdata),
    .window_length (window_length),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_count     (m_axis_tdata)
  );

endmodule

// ===== design/swhc_ctrl.sv =====
module swhc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  swhc_pkg::dp_status_t  status,
  output swhc_pkg::ctrl_cmd_t   cmd
);
  import swhc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        // no transaction is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (!status.is_query && status.hit_simple) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (status.old_head) begin
          cmd.pop = 1'b1;
        end else if (status.is_query) begin
          if (status.out_free) begin
            cmd.out_load = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_OUT_WAIT;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT_WAIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/swhc_dp.sv =====
module swhc_dp #(
  parameter int unsigned RING_DEPTH = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  swhc_pkg::ctrl_cmd_t               cmd,
  output swhc_pkg::dp_status_t              status,
  input  logic                              in_command,
  input  logic [swhc_pkg::DATA_W-1:0]       in_time,
  input  logic [swhc_pkg::WIN_W-1:0]        window_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [swhc_pkg::DATA_W-1:0]       out_count
);
  import swhc_pkg::*;

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned OW = $clog2(RING_DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(RING_DEPTH - 1);
  localparam logic [OW-1:0] OCC_FULL = OW'(RING_DEPTH);

  logic [DATA_W-1:0] record_time  [RING_DEPTH];
  logic [DATA_W-1:0] record_count [RING_DEPTH];

  logic              cmd_q;
  logic [DATA_W-1:0] time_q;
  logic [PW-1:0]     head, head_next;
  logic [PW-1:0]     tail, tail_next;
  logic [OW-1:0]     occ, occ_next;
  logic [DATA_W-1:0] total, total_next;
  logic [DATA_W-1:0] last_time, last_count;
  logic [DATA_W-1:0] rd_time, rd_count;

  logic              occ_zero, match_last, is_full;
  logic              do_push, do_bump, drop;
  logic              we;
  logic [PW-1:0]     waddr, tail_prev;
  logic [DATA_W-1:0] wtime, wcount;
  logic [DATA_W-1:0] total_sub, age, bump_count;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  assign occ_zero   = (occ == '0);
  assign match_last = (last_time == time_q);
  assign is_full    = (occ == OCC_FULL);
  assign tail_prev  = (tail == '0) ? LAST_IDX : tail - 1'b1;

  assign do_push = cmd.exec && (cmd_q == CMD_HIT) && (occ_zero || !match_last);
  assign do_bump = cmd.exec && (cmd_q == CMD_HIT) && !occ_zero && match_last;
  // head leaves on an eviction pop or when a push finds the ring full
  assign drop    = cmd.pop || (do_push && is_full);

  assign bump_count = sat_inc(last_count);
  assign total_sub  = (rd_count > total) ? '0 : total - rd_count;
  assign age        = time_q - rd_time;

  always_comb begin
    head_next  = drop ? ring_next(head) : head;
    tail_next  = do_push ? ring_next(tail) : tail;
    occ_next   = occ;
    total_next = total;
    we         = 1'b0;
    waddr      = tail;
    wtime      = time_q;
    wcount     = DATA_W'(1);
    if (do_push) begin
      we         = 1'b1;
      total_next = is_full ? sat_inc(total_sub) : sat_inc(total);
      occ_next   = is_full ? occ : occ + 1'b1;
    end else if (do_bump) begin
      we         = 1'b1;
      waddr      = tail_prev;
      wtime      = last_time;
      wcount     = bump_count;
      total_next = sat_inc(total);
    end else if (cmd.pop) begin
      total_next = total_sub;
      occ_next   = occ - 1'b1;
    end
  end

  // read port follows the next head; write-first on an address clash
  always_ff @(posedge clk) begin
    if (we) begin
      record_time[waddr]  <= wtime;
      record_count[waddr] <= wcount;
    end
    if (we && (waddr == head_next)) begin
      rd_time  <= wtime;
      rd_count <= wcount;
    end else begin
      rd_time  <= record_time[head_next];
      rd_count <= record_count[head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      occ   <= occ_next;
      total <= total_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= in_command;
      time_q <= in_time;
    end
    if (do_push) begin
      last_time  <= time_q;
      last_count <= DATA_W'(1);
    end else if (do_bump) begin
      last_count <= bump_count;
    end
    if (cmd.out_load) begin
      out_count <= total;
    end
  end

  assign status.is_query   = (cmd_q == CMD_QUERY);
  assign status.hit_simple = occ_zero || match_last;
  assign status.old_head   = !occ_zero && (age >= DATA_W'(window_length));
  assign status.out_free   = !out_valid || out_ready;

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swhc_pkg::*;

  localparam int unsigned RING_DEPTH    = 512;
  localparam logic [2:0]  ADDR_WINDOW   = 3'd0;
  localparam int          SETTLE_CYCLES = 600;   // worst eviction walks the whole ring
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          RANDOM_ITEMS  = 1750;

  // Tracks the ring of (time, count) records and queues the hit count
  // each query should return.
  class hit_window_tracker;
    bit [31:0]      rec_time [RING_DEPTH];
    bit [31:0]      rec_count[RING_DEPTH];
    int unsigned    head;
    int unsigned    tail;
    int unsigned    fill;
    bit [31:0]      total;
    bit [WIN_W-1:0] window;
    bit [31:0]      pending_counts[$];
    int             errors;

    function new();
      window = WINDOW_RESET;
    endfunction

    function void drop_oldest();
      total = (rec_count[head] > total) ? 32'd0 : total - rec_count[head];
      head  = (head + 1 == RING_DEPTH) ? 0 : head + 1;
      fill--;
    endfunction

    function void push_time(bit [31:0] t);
      if (fill >= RING_DEPTH) drop_oldest();
      rec_time[tail]  = t;
      rec_count[tail] = 32'd1;
      tail = (tail + 1 == RING_DEPTH) ? 0 : tail + 1;
      fill++;
      if (total != COUNT_MAX) total++;
    endfunction

    function void evict_aged(bit [31:0] t);
      bit [31:0] age;
      while (fill > 0) begin
        age = t - rec_time[head];   // modulo 2^32 on purpose
        if (age < window) break;
        drop_oldest();
      end
    endfunction

    function void take_item(logic cmd, bit [31:0] t);
      int unsigned newest;
      if (cmd == CMD_QUERY) begin
        evict_aged(t);
        pending_counts.push_back(total);
      end else if (fill == 0) begin
        push_time(t);
      end else begin
        newest = (tail == 0) ? RING_DEPTH - 1 : tail - 1;
        if (rec_time[newest] == t) begin
          if (rec_count[newest] != COUNT_MAX) rec_count[newest]++;
          if (total != COUNT_MAX) total++;
        end else begin
          push_time(t);
          evict_aged(t);
        end
      end
    endfunction

    function void check_count(logic [31:0] got);
      bit [31:0] want;
      if (pending_counts.size() == 0) begin
        $display("%0t: hit_count expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = pending_counts.pop_front();
      if (got !== want) begin
        $display("%0t: hit_count expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] timestamp
  logic [0:0]  s_axis_tuser;   // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] hit_count
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hit_window_tracker tracker = new();
  bit                quiet;
  int                sent;
  int                cycles;
  bit [31:0]         now;

  sliding_window_hit_counter_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sliding_window_hit_counter_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_count(m_axis_tdata);
  end

  // mostly short gaps, a few long ones; none during quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (quiet || $urandom_range(0, 1)) begin
        m_axis_tready <= 1'b1;
        hold = quiet ? 0 : $urandom_range(0, 15);
      end else begin
        m_axis_tready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [31:0] ts);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= ts;
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_item(cmd, ts);
    sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending_counts.size() != 0);
  endtask

  // A hit may still be evicting after the last query result, so let it settle.
  task automatic set_window(input logic [WIN_W-1:0] w);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW;
    pwdata  <= 32'(w);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.window = w;
  endtask

  task automatic run_phase(input int phase_len, input bit stress_ring);
    int        done;
    int        burst_len;
    int        span;
    int        r;
    bit [31:0] base;
    done = 0;
    span = (tracker.window / 4 > 0) ? tracker.window / 4 : 1;
    if (stress_ring) begin
      // head stays in the window while alternating times keep pushing
      // records, so the ring fills and drops its oldest entry
      base = now;
      send_item(CMD_HIT, base);
      for (int k = 0; k < 540; k++) send_item(CMD_HIT, base + 32'd1 + 32'(k % 2));
      send_item(CMD_QUERY, base + 32'd2);
      now = base + 32'd2;
    end
    while (done < phase_len) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        wait_idle();
      end else if (r < 88) begin
        burst_len = $urandom_range(5, 30);
        for (int k = 0; k < burst_len; k++) begin
          r = $urandom_range(0, 99);
          if (r >= 40 && r < 85) now += 32'($urandom_range(1, span));
          else if (r >= 85 && r < 97) now += 32'($urandom_range(1, tracker.window + 2));
          else if (r >= 97) now += $urandom;
          send_item(($urandom_range(0, 99) < 30) ? CMD_QUERY : CMD_HIT, now);
        end
        done += burst_len;
      end else begin
        // noise: arbitrary times, backwards jumps included
        burst_len = $urandom_range(1, 5);
        for (int k = 0; k < burst_len; k++) begin
          now = $urandom;
          send_item(1'($urandom_range(0, 1)), now);
        end
        done += burst_len;
      end
    end
  endtask

  initial begin
    int             phase;
    int             target;
    logic [WIN_W-1:0] w;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= CMD_HIT;
    s_axis_tdata  <= 32'd0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= ADDR_WINDOW;
    pwdata        <= 32'd0;
    sent           = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // window at its reset value
    send_item(CMD_QUERY, 32'd0);           // empty ring
    send_item(CMD_HIT,   32'd5);           // push on empty ring
    send_item(CMD_HIT,   32'd5);           // same time as newest: bump
    send_item(CMD_QUERY, 32'd5);
    send_item(CMD_HIT,   32'd304);
    send_item(CMD_QUERY, 32'd304);
    send_item(CMD_QUERY, 32'd305);         // age equals window: evicted
    send_item(CMD_HIT,   32'hFFFF_FFF0);
    send_item(CMD_HIT,   32'hFFFF_FFFF);
    send_item(CMD_HIT,   32'd0);           // wraps, age stays small
    send_item(CMD_QUERY, 32'd3);
    send_item(CMD_HIT,   32'd1);           // time steps backwards
    send_item(CMD_QUERY, 32'd0);
    send_item(CMD_HIT,   32'h8000_0000);
    send_item(CMD_QUERY, 32'h8000_0000);

    // zero window: everything is old
    set_window('0);
    send_item(CMD_HIT,   32'd10);
    send_item(CMD_HIT,   32'd10);
    send_item(CMD_HIT,   32'd12);          // push then evict all
    send_item(CMD_QUERY, 32'd12);

    set_window(9'd1);
    send_item(CMD_HIT,   32'd20);
    send_item(CMD_HIT,   32'd20);
    send_item(CMD_QUERY, 32'd20);
    send_item(CMD_QUERY, 32'd21);

    set_window(9'd511);
    send_item(CMD_HIT,   32'd0);
    send_item(CMD_QUERY, 32'd510);
    send_item(CMD_QUERY, 32'd511);

    target = sent + RANDOM_ITEMS;
    phase  = 0;
    while (sent < target) begin
      case (phase % 6)
        0:       w = 9'd511;
        1:       w = 9'd1;
        2:       w = '0;
        default: w = WIN_W'($urandom_range(3, 510));
      endcase
      set_window(w);
      now   = $urandom;
      quiet = (phase % 4 == 3);
      run_phase($urandom_range(60, 200), phase == 3);
      phase++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("PASS sliding_window_hit_counter_core");
    else $display("FAIL sliding_window_hit_counter_core");
    $finish;
  end

endmodule
